// ----- src/fus_pkg.sv -----
// ----------------------------------------------------------------------------
// Firmware upload sequencer package
// Shared types and codes for the upload sequencer modules.
// ----------------------------------------------------------------------------
package fus_pkg;

  localparam int unsigned IN_W   = 56;
  localparam int unsigned USER_W = 5;
  localparam int unsigned OUT_W  = 80;

  typedef enum logic [2:0] {
    OP_INIT = 3'd0, OP_LOAD = 3'd1, OP_START = 3'd2,
    OP_RESP = 3'd3, OP_ABORT = 3'd4, OP_TICK = 3'd5
  } op_t;

  typedef enum logic [3:0] {
    PH_UNSUP = 4'd0, PH_NOTREADY = 4'd1, PH_LOADED = 4'd2, PH_ERASING = 4'd3,
    PH_SENDING = 4'd4, PH_WAITING = 4'd5, PH_FINAL = 4'd6, PH_DONE = 4'd7,
    PH_ABORTED = 4'd8, PH_ERROR = 4'd9
  } phase_t;

  localparam logic [3:0] F_NONE = 4'd0, F_LOAD = 4'd1, F_NOTLOADED = 4'd2,
    F_BADRESP = 4'd3, F_REMOTE = 4'd4, F_ERASE_TO = 4'd5, F_READY_TO = 4'd6,
    F_PROG_TO = 4'd7, F_SEQ = 4'd8, F_RETRIES = 4'd9;

  localparam logic [1:0] REQ_NONE = 2'd0, REQ_STATUS = 2'd1, REQ_DATA = 2'd2;
  localparam logic [1:0] KIND_UPGRADE = 2'd0, KIND_CONFIG = 2'd1;

  typedef enum logic [2:0] {
    CFG_CHUNK = 3'd0, CFG_ERASE = 3'd1, CFG_BUSY = 3'd2, CFG_PROG = 3'd3,
    CFG_NOREPLY = 3'd4, CFG_RETRY = 3'd5, CFG_REFRESH = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [23:0] image_bytes;
    logic        load_ok;
    logic [7:0]  seq_id;
    logic        verify_flag;
    logic        programmed_flag;
    logic        prog_fifo_full;
    logic        ready_flag;
    logic        erased_flag;
    logic [10:0] error_flags;
    logic        response_ok;
    logic [1:0]  command_kind;
    logic [2:0]  operation;
  } req_t;

  typedef struct packed {
    logic [3:0]  fault_code;
    logic [15:0] all_retries;
    logic [7:0]  run_retries;
    logic [1:0]  config_writes;
    logic [12:0] chunk_length;
    logic [1:0]  upgrade_request;
    logic [23:0] position;
    logic [3:0]  phase;
    logic        handled;
  } res_t;

  typedef struct packed {
    logic [12:0] chunk;
    logic [19:0] erase_limit;
    logic [19:0] busy_limit;
    logic [19:0] program_limit;
    logic [16:0] no_reply;
    logic [7:0]  retry_limit;
    logic [16:0] refresh;
  } cfg_t;

endpackage

// ----- src/fus_cfg.sv -----
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the limits and chunk size; chunk size and periods are normalized here.
// ----------------------------------------------------------------------------
module fus_cfg (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_addr,
  input  logic [19:0]   cfg_wdata,
  output fus_pkg::cfg_t cfg
);
  logic [12:0] chunk_raw;
  logic [13:0] chunk_up;
  logic [16:0] noreply_raw, refresh_raw;
  logic [19:0] erase_lim, busy_lim, prog_lim;
  logic [7:0]  retry_lim;

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_raw <= 13'd256;
      erase_lim <= 20'd120000;
      busy_lim <= 20'd1000;
      prog_lim <= 20'd10000;
      noreply_raw <= 17'd200;
      retry_lim <= 8'd5;
      refresh_raw <= 17'd1000;
    end else if (cfg_we) begin
      case (cfg_addr)
        fus_pkg::CFG_CHUNK:   chunk_raw <= cfg_wdata[12:0];
        fus_pkg::CFG_ERASE:   erase_lim <= cfg_wdata;
        fus_pkg::CFG_BUSY:    busy_lim <= cfg_wdata;
        fus_pkg::CFG_PROG:    prog_lim <= cfg_wdata;
        fus_pkg::CFG_NOREPLY: noreply_raw <= cfg_wdata[16:0];
        fus_pkg::CFG_RETRY:   retry_lim <= cfg_wdata[7:0];
        fus_pkg::CFG_REFRESH: refresh_raw <= cfg_wdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    chunk_up = ({1'b0, chunk_raw} + 14'd3) & ~14'd3;
    cfg.chunk = (chunk_up > 14'd4096) ? 13'd4096 : chunk_up[12:0];
    cfg.erase_limit = erase_lim;
    cfg.busy_limit = busy_lim;
    cfg.program_limit = prog_lim;
    cfg.no_reply = (noreply_raw == '0) ? 17'd1 : noreply_raw;
    cfg.retry_limit = retry_lim;
    cfg.refresh = (refresh_raw == '0) ? 17'd1 : refresh_raw;
  end
endmodule

// ----- src/fus_core.sv -----
// ----------------------------------------------------------------------------
// Sequencer state and decision logic
// Decides the step from the registered request and registers the state and the result.
// ----------------------------------------------------------------------------
module fus_core #(
  parameter int unsigned SEQ_BITS = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  fus_pkg::cfg_t cfg,
  input  logic          in_go,
  input  fus_pkg::req_t req,
  output fus_pkg::res_t res
);
  fus_pkg::phase_t phase, phase_next;
  logic [23:0] offset, offset_next, size, size_next;
  logic [12:0] last_len, last_len_next;
  logic [SEQ_BITS-1:0] expect_seq, expect_seq_next;
  logic [1:0]  pending, pending_next;
  logic [7:0]  seq_retry, seq_retry_next;
  logic [15:0] tot_retry, tot_retry_next;
  logic [31:0] tick_now, tick_next, phase_start, phase_start_next;
  logic [31:0] reply_dl, reply_dl_next, refresh_due, refresh_due_next;
  logic        reply_armed, reply_armed_next, refresh_armed, refresh_armed_next;
  fus_pkg::res_t r;

  logic        active, errs, seq_match;
  logic [31:0] elapsed, tnow;
  logic [23:0] avail;
  logic [12:0] len;

  always_comb begin
    phase_next = phase; offset_next = offset; size_next = size;
    last_len_next = last_len; expect_seq_next = expect_seq;
    pending_next = pending; seq_retry_next = seq_retry; tot_retry_next = tot_retry;
    tick_next = tick_now; phase_start_next = phase_start;
    reply_dl_next = reply_dl; refresh_due_next = refresh_due;
    reply_armed_next = reply_armed; refresh_armed_next = refresh_armed;
    r = '0;
    active = (phase == fus_pkg::PH_ERASING) || (phase == fus_pkg::PH_SENDING) ||
             (phase == fus_pkg::PH_WAITING) || (phase == fus_pkg::PH_FINAL);
    errs = |req.error_flags;
    tnow = (req.operation == fus_pkg::OP_TICK) ? tick_now + 32'd1 : tick_now;
    elapsed = tnow - phase_start;
    seq_match = (16'(expect_seq) == 16'(req.seq_id));
    avail = 24'd0; len = 13'd0;
    case (req.operation)
      fus_pkg::OP_INIT: begin
        if (phase == fus_pkg::PH_UNSUP) begin
          phase_next = fus_pkg::PH_NOTREADY;
          pending_next = '0; seq_retry_next = '0; tot_retry_next = '0; size_next = '0;
          r.handled = 1'b1;
        end
      end
      fus_pkg::OP_LOAD: begin
        if (phase == fus_pkg::PH_NOTREADY || phase == fus_pkg::PH_LOADED ||
            phase == fus_pkg::PH_DONE || phase == fus_pkg::PH_ABORTED ||
            phase == fus_pkg::PH_ERROR) begin
          if (req.load_ok) begin
            phase_next = fus_pkg::PH_LOADED; size_next = req.image_bytes;
            r.handled = 1'b1;
          end else begin
            size_next = '0; phase_next = fus_pkg::PH_ERROR; r.fault_code = fus_pkg::F_LOAD;
          end
        end
      end
      fus_pkg::OP_START: begin
        if (phase == fus_pkg::PH_LOADED || phase == fus_pkg::PH_DONE ||
            phase == fus_pkg::PH_ABORTED || phase == fus_pkg::PH_ERROR) begin
          if (size == '0) begin
            r.fault_code = fus_pkg::F_NOTLOADED;
          end else begin
            offset_next = '0; last_len_next = '0; seq_retry_next = '0; tot_retry_next = '0;
            pending_next = 2'd2; r.config_writes = 2'd2;
            refresh_due_next = tick_now + {15'd0, cfg.refresh}; refresh_armed_next = 1'b1;
            phase_start_next = tick_now; phase_next = fus_pkg::PH_ERASING;
            r.handled = 1'b1;
          end
        end
      end
      fus_pkg::OP_RESP: begin
        reply_armed_next = 1'b0;
        if (req.command_kind != fus_pkg::KIND_UPGRADE) begin
          if (req.command_kind == fus_pkg::KIND_CONFIG && pending != '0) begin
            pending_next = pending - 2'd1; r.handled = 1'b1;
          end
        end else if (!req.response_ok) begin
          phase_next = fus_pkg::PH_ERROR; r.fault_code = fus_pkg::F_BADRESP;
        end else if (phase == fus_pkg::PH_ERASING) begin
          r.handled = 1'b1; seq_retry_next = '0;
          if (errs) begin
            phase_next = fus_pkg::PH_ERROR; r.fault_code = fus_pkg::F_REMOTE;
            refresh_armed_next = 1'b0;
          end else if (req.erased_flag) begin
            phase_start_next = tick_now; phase_next = fus_pkg::PH_SENDING;
            refresh_armed_next = 1'b0; r.upgrade_request = fus_pkg::REQ_STATUS;
            expect_seq_next = '0;
          end else if (elapsed > {12'd0, cfg.erase_limit}) begin
            phase_next = fus_pkg::PH_ERROR; r.fault_code = fus_pkg::F_ERASE_TO;
            refresh_armed_next = 1'b0;
          end
        end else if (phase == fus_pkg::PH_SENDING || phase == fus_pkg::PH_WAITING) begin
          r.handled = 1'b1;
          if (errs) begin
            phase_next = fus_pkg::PH_ERROR; r.fault_code = fus_pkg::F_REMOTE;
          end else if (req.ready_flag && !req.prog_fifo_full) begin
            phase_start_next = tick_now;
            if (!seq_match && seq_retry >= cfg.retry_limit) begin
              phase_next = fus_pkg::PH_ERROR; r.fault_code = fus_pkg::F_SEQ;
            end else begin
              if (seq_match) begin
                offset_next = offset + {11'd0, last_len};
                expect_seq_next = expect_seq + SEQ_BITS'(1);
                seq_retry_next = '0;
              end else begin
                seq_retry_next = seq_retry + 8'd1;
                if (tot_retry != 16'hFFFF) tot_retry_next = tot_retry + 16'd1;
              end
              avail = (offset_next < size) ? size - offset_next : 24'd0;
              len = ({11'd0, cfg.chunk} < avail) ? cfg.chunk : avail[12:0];
              last_len_next = len;
              if (len == '0) begin
                phase_next = fus_pkg::PH_FINAL;
                refresh_due_next = tick_now + {15'd0, cfg.refresh};
                refresh_armed_next = 1'b1;
              end else begin
                phase_next = fus_pkg::PH_SENDING;
                r.upgrade_request = fus_pkg::REQ_DATA; r.chunk_length = len;
                reply_dl_next = tick_now + {15'd0, cfg.no_reply}; reply_armed_next = 1'b1;
              end
            end
          end else begin
            seq_retry_next = '0;
            if (elapsed > {12'd0, cfg.busy_limit}) begin
              phase_next = fus_pkg::PH_ERROR; r.fault_code = fus_pkg::F_READY_TO;
            end else begin
              phase_next = fus_pkg::PH_WAITING; r.upgrade_request = fus_pkg::REQ_STATUS;
              reply_dl_next = tick_now + {15'd0, cfg.no_reply}; reply_armed_next = 1'b1;
            end
          end
        end else if (phase == fus_pkg::PH_FINAL) begin
          r.handled = 1'b1; seq_retry_next = '0;
          if (errs) begin
            phase_next = fus_pkg::PH_ERROR; r.fault_code = fus_pkg::F_REMOTE;
            refresh_armed_next = 1'b0;
          end else if (req.programmed_flag && req.verify_flag) begin
            phase_next = fus_pkg::PH_DONE; refresh_armed_next = 1'b0;
            if (pending != 2'd3) pending_next = pending + 2'd1;
            r.config_writes = 2'd1;
          end else if (elapsed > {12'd0, cfg.program_limit}) begin
            phase_next = fus_pkg::PH_ERROR; r.fault_code = fus_pkg::F_PROG_TO;
            refresh_armed_next = 1'b0;
          end
        end
      end
      fus_pkg::OP_ABORT: begin
        if (active) begin
          reply_armed_next = 1'b0; refresh_armed_next = 1'b0;
          phase_next = fus_pkg::PH_ABORTED; r.handled = 1'b1;
        end
      end
      fus_pkg::OP_TICK: begin
        tick_next = tnow;
        if (reply_armed && reply_dl == tnow) begin
          reply_armed_next = 1'b0;
          if (active) begin
            r.handled = 1'b1;
            if (seq_retry >= cfg.retry_limit) begin
              phase_next = fus_pkg::PH_ERROR; r.fault_code = fus_pkg::F_RETRIES;
            end else begin
              r.upgrade_request = fus_pkg::REQ_STATUS;
              seq_retry_next = seq_retry + 8'd1;
              if (tot_retry != 16'hFFFF) tot_retry_next = tot_retry + 16'd1;
              reply_dl_next = tnow + {15'd0, cfg.no_reply}; reply_armed_next = 1'b1;
            end
          end
        end
        if (refresh_armed && refresh_due == tnow) begin
          r.handled = 1'b1; r.upgrade_request = fus_pkg::REQ_STATUS;
          reply_dl_next = tnow + {15'd0, cfg.no_reply}; reply_armed_next = 1'b1;
          refresh_due_next = tnow + {15'd0, cfg.refresh};
        end
      end
      default: ;
    endcase
    r.phase = phase_next;
    r.position = offset_next;
    r.run_retries = seq_retry_next;
    r.all_retries = tot_retry_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= fus_pkg::PH_UNSUP; offset <= '0; size <= '0; last_len <= '0;
      expect_seq <= '0; pending <= '0; seq_retry <= '0; tot_retry <= '0;
      tick_now <= '0; phase_start <= '0; reply_dl <= '0; refresh_due <= '0;
      reply_armed <= 1'b0; refresh_armed <= 1'b0;
    end else if (in_go) begin
      phase <= phase_next; offset <= offset_next; size <= size_next;
      last_len <= last_len_next; expect_seq <= expect_seq_next; pending <= pending_next;
      seq_retry <= seq_retry_next; tot_retry <= tot_retry_next; tick_now <= tick_next;
      phase_start <= phase_start_next; reply_dl <= reply_dl_next;
      refresh_due <= refresh_due_next; reply_armed <= reply_armed_next;
      refresh_armed <= refresh_armed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_go) res <= r;
  end
endmodule

// ----- src/firmware_upload_sequencer_core.sv -----
// ----------------------------------------------------------------------------
// Firmware upload sequencer
// Event-driven sequencer for a remote flash upgrade over a command link.
// ----------------------------------------------------------------------------
// Each event request yields one result request. An event is registered, decided
// combinationally against the session state and the result is held in an output
// register, so a new event is taken every cycle while the output is free or
// being taken. Configuration is to be written through cfg_we/cfg_addr/cfg_wdata
// by the user only while no event is in flight; the block does not enforce this.
module firmware_upload_sequencer_core #(
  parameter int unsigned SEQ_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [19:0] cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // operation, command_kind
  input  logic [fus_pkg::USER_W-1:0] s_axis_tuser,
  // response_ok, error_flags, erased_flag, ready_flag, prog_fifo_full,
  // programmed_flag, verify_flag, seq_id, load_ok, image_bytes
  input  logic [fus_pkg::IN_W-1:0]   s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // handled, phase, position, upgrade_request, chunk_length, config_writes,
  // run_retries, all_retries, fault_code
  output logic [fus_pkg::OUT_W-1:0]  m_axis_tdata
);
  fus_pkg::cfg_t cfg;
  fus_pkg::req_t req;
  fus_pkg::res_t res;
  logic in_valid, in_go;

  fus_cfg u_cfg (.clk, .rst, .cfg_we, .cfg_addr, .cfg_wdata, .cfg);

  // The input stage advances whenever the output register can take its result.
  assign in_go = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || in_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tready) in_valid <= s_axis_tvalid;
      if (in_go) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) req <= {s_axis_tdata[49:0], s_axis_tuser};
  end

  fus_core #(.SEQ_BITS(SEQ_BITS)) u_core (.clk, .rst, .cfg, .in_go, .req, .res);

  assign m_axis_tdata = {6'd0, res.fault_code, res.all_retries, res.run_retries,
    res.config_writes, res.chunk_length, res.upgrade_request, res.position,
    res.phase, res.handled};
endmodule
